// File: rtl/udp_payload_pattern_filter_defines.svh
// assertion macros for the udp payload pattern filter
// used by the top level only; needs clk_i and rst_ni in the including scope
`ifndef UDP_PAYLOAD_PATTERN_FILTER_DEFINES_SVH
`define UDP_PAYLOAD_PATTERN_FILTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define UPPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define UPPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/uppf_pkg.sv
// shared constants, types and helpers of the udp payload pattern filter
// no dependencies
package uppf_pkg;

  localparam int MaxPatternBytes = 16;
  localparam int UdpHeaderBytes  = 8;
  localparam int LenW            = 5;
  localparam int SeenW           = $clog2(MaxPatternBytes + 1);
  localparam int PosW            = 16;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 64;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgFilterPresent = 3'd0,
    CfgPatternLength = 3'd1,
    CfgPatternLow    = 3'd2,
    CfgPatternHigh   = 3'd3,
    CfgReplace       = 3'd4
  } cfg_reg_e;

  typedef logic [MaxPatternBytes-1:0][7:0] window_t;

  typedef struct packed {
    logic [LenW-1:0] len;      // active length, 0..MaxPatternBytes
    window_t         pattern;  // byte 0 in element 0
  } match_cfg_t;

  // pattern length clipped to the window size
  function automatic logic [LenW-1:0] active_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] cap;
    cap = LenW'(MaxPatternBytes);
    return (len > cap) ? cap : len;
  endfunction

endpackage

// File: rtl/uppf_matcher.sv
// parallel compare of the payload window against the configured pattern
// depends on uppf_pkg
module uppf_matcher (
  input  uppf_pkg::window_t               win_i,   // entry 0 newest
  input  logic [uppf_pkg::SeenW-1:0]      seen_i,  // payload bytes seen, saturated
  input  uppf_pkg::match_cfg_t            cfg_i,
  output logic                            match_o
);

  always_comb begin
    logic [uppf_pkg::LenW-1:0] idx;
    idx     = '0;
    match_o = (cfg_i.len != '0) && (uppf_pkg::LenW'(seen_i) >= cfg_i.len);
    // pattern byte i sits at window entry len-1-i
    for (int i = 0; i < uppf_pkg::MaxPatternBytes; i++) begin
      idx = cfg_i.len - uppf_pkg::LenW'(1) - uppf_pkg::LenW'(i);
      if ((uppf_pkg::LenW'(i) < cfg_i.len) &&
          (win_i[idx[$clog2(uppf_pkg::MaxPatternBytes)-1:0]] != cfg_i.pattern[i])) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

// File: rtl/udp_payload_pattern_filter.sv
// top level of the udp payload pattern filter: input stage, packet state, verdict register
// depends on uppf_pkg, uppf_matcher and udp_payload_pattern_filter_defines.svh
//
//   channel   | dir | handshake                    | contents
//   ----------+-----+------------------------------+----------------------------------------
//   s_axis    | in  | tvalid/tready                | tdata: packet_byte, ip_header_bytes
//             |     |                              | tlast: last_byte
//   m_axis    | out | tvalid/tready                | tdata: verdict, pattern_found, zero pad
//   cfg       | in  | cfg_we_i (no back pressure)  | cfg_idx_i register index, cfg_data_i
//
// one byte per cycle while no last byte waits on a stalled verdict; an accepted byte is
// registered, then processed; a verdict is on m_axis in the cycle after the last byte is processed
// the pattern compare is a parallel byte compare over the 16-entry window, one pass per byte
// reset clears valid flags, config, position, seen count and match flag; no clearing pass is needed
// a stalled verdict holds back only a last byte in the input stage; new bytes wait behind it
`include "udp_payload_pattern_filter_defines.svh"

module udp_payload_pattern_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [7:0] packet_byte, [15:8] ip_header_bytes
  input  logic                              s_axis_tlast,   // last_byte
  // verdict stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [0] verdict, [1] pattern_found, [7:2] zero
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [uppf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [uppf_pkg::CfgDataW-1:0]     cfg_data_i
);

  // configuration registers
  logic                          cfg_filter_q;
  logic [uppf_pkg::LenW-1:0]     cfg_len_q;
  logic [63:0]                   cfg_lo_q;
  logic [63:0]                   cfg_hi_q;
  logic                          cfg_repl_q;

  // input stage
  logic                          in_valid_q, in_valid_d;
  logic [7:0]                    in_byte_q;
  logic [7:0]                    in_hdr_q;
  logic                          in_last_q;

  // packet state
  logic [uppf_pkg::PosW-1:0]     pos_q, pos_d;
  logic [uppf_pkg::SeenW-1:0]    seen_q, seen_d;
  logic                          match_seen_q, match_seen_d;
  uppf_pkg::window_t             win_q;

  // verdict register
  logic                          out_valid_q, out_valid_d;
  logic                          out_verdict_q;
  logic                          out_found_q;

  logic                          advance;
  logic                          examine;
  logic [uppf_pkg::PosW-1:0]     payload_start;
  logic [uppf_pkg::SeenW-1:0]    seen_inc;
  uppf_pkg::window_t             win_new;
  uppf_pkg::match_cfg_t          mcfg;
  logic                          match_now;
  logic                          match_any;
  logic                          verdict_d;
  logic                          found_d;

  // assertion helpers
  logic                          last_taken;
  logic                          pkt_clear;
  logic                          in_held;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_filter_q <= 1'b0;
      cfg_len_q    <= '0;
      cfg_lo_q     <= '0;
      cfg_hi_q     <= '0;
      cfg_repl_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (uppf_pkg::cfg_reg_e'(cfg_idx_i))
        uppf_pkg::CfgFilterPresent: cfg_filter_q <= cfg_data_i[0];
        uppf_pkg::CfgPatternLength: cfg_len_q    <= cfg_data_i[uppf_pkg::LenW-1:0];
        uppf_pkg::CfgPatternLow:    cfg_lo_q     <= cfg_data_i;
        uppf_pkg::CfgPatternHigh:   cfg_hi_q     <= cfg_data_i;
        uppf_pkg::CfgReplace:       cfg_repl_q   <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  // a last byte needs room in the verdict register; other bytes always move on
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_hdr_q  <= s_axis_tdata[15:8];
      in_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // per-byte processing
  // ---------------------------------------------------------------------------
  // payload starts after the ip header and the fixed udp header;
  // the saturated top position is never examined
  assign payload_start = uppf_pkg::PosW'(in_hdr_q) + uppf_pkg::PosW'(uppf_pkg::UdpHeaderBytes);
  assign examine       = (pos_q != uppf_pkg::PosMax) && (pos_q >= payload_start);

  assign seen_inc = (seen_q == uppf_pkg::SeenW'(uppf_pkg::MaxPatternBytes)) ?
                    seen_q : seen_q + uppf_pkg::SeenW'(1);

  // window after shifting in the current byte
  always_comb begin
    win_new[0] = in_byte_q;
    for (int k = 1; k < uppf_pkg::MaxPatternBytes; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  assign mcfg.len     = uppf_pkg::active_len(cfg_len_q);
  assign mcfg.pattern = {cfg_hi_q, cfg_lo_q};

  uppf_matcher u_matcher (
    .win_i   (win_new),
    .seen_i  (seen_inc),
    .cfg_i   (mcfg),
    .match_o (match_now)
  );

  assign match_any = match_seen_q || (examine && match_now);

  // packet state next values, cleared after each verdict
  always_comb begin
    pos_d        = pos_q;
    seen_d       = seen_q;
    match_seen_d = match_seen_q;
    if (advance) begin
      if (in_last_q) begin
        pos_d        = '0;
        seen_d       = '0;
        match_seen_d = 1'b0;
      end else begin
        if (pos_q != uppf_pkg::PosMax) begin
          pos_d = pos_q + uppf_pkg::PosW'(1);
        end
        if (examine) begin
          seen_d       = seen_inc;
          match_seen_d = match_any;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      seen_q       <= '0;
      match_seen_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      seen_q       <= seen_d;
      match_seen_q <= match_seen_d;
    end
  end

  // window entries past the seen count are never compared, so no reset or clear
  always_ff @(posedge clk_i) begin
    if (advance && examine) begin
      win_q <= win_new;
    end
  end

  // ---------------------------------------------------------------------------
  // verdict
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (!cfg_filter_q) begin
      verdict_d = 1'b1;
      found_d   = 1'b0;
    end else if (mcfg.len == '0) begin
      verdict_d = 1'b0;
      found_d   = 1'b0;
    end else begin
      verdict_d = match_any && !cfg_repl_q;
      found_d   = match_any;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_verdict_q <= verdict_d;
      out_found_q   <= found_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_found_q, out_verdict_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  assign last_taken = advance && in_last_q;
  assign pkt_clear  = (pos_q == '0) && (seen_q == '0) && !match_seen_q;
  assign in_held    = in_valid_q && !advance;

  // a new verdict only comes from a processed last byte
  `UPPF_ASSERT_SAME(a_verdict_from_last, $rose(out_valid_q), $past(last_taken), "stray verdict")
  // packet state is clear right after a verdict is taken in
  `UPPF_ASSERT_NEXT(a_clear_after_last, last_taken, pkt_clear, "packet state not cleared")
  // a held byte in the input stage is not overwritten
  `UPPF_ASSERT_NEXT(a_input_held, in_held, in_valid_q && $stable({in_byte_q, in_last_q}), "byte lost")

endmodule

// File: sim/tb_udp_payload_pattern_filter.sv
// self-checking testbench for udp_payload_pattern_filter: random byte stream with planted patterns
// depends on uppf_pkg and the filter rtl; predicts each verdict from its own copy of packet state
`timescale 1ns / 100ps

module tb_udp_payload_pattern_filter;
  import uppf_pkg::*;

  localparam int CycleLimit   = 100_000;    // all traffic under the slowest idling, many times over
  localparam int SettleCycles = 8;          // byte register + processing + verdict register, with slack
  localparam logic [CfgIdxW-1:0] CfgUnmapped = {CfgIdxW{1'b1}};

  // one packet byte as it travels on the input stream
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] hdr;
    logic       is_last;
  } pkt_byte_t;

  // one verdict transaction
  typedef struct packed {
    logic block;
    logic found;
  } verdict_t;

  // how a random packet is built around the configured pattern
  typedef enum {ShapePlain, ShapeHit, ShapeCut, ShapeInHeader, ShapeNoise} shape_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;    // [7:0] packet_byte, [15:8] ip_header_bytes
  logic                s_axis_tlast = 1'b0;  // last_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [0] verdict, [1] pattern_found, [7:2] zero
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  udp_payload_pattern_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // mirror of the configuration registers, updated as each write lands
  logic                cfg_present = 1'b0;
  logic [LenW-1:0]     cfg_len = '0;
  logic [63:0]         cfg_pat_lo = '0;
  logic [63:0]         cfg_pat_hi = '0;
  logic                cfg_replace = 1'b0;

  // per-packet state of the filter as predicted
  logic [PosW-1:0]     pkt_pos = '0;
  logic [PosW-1:0]     payload_cnt = '0;
  logic [7:0]          win [MaxPatternBytes] = '{default: 8'h00};  // entry 0 newest
  logic                hit = 1'b0;

  pkt_byte_t           byte_q [$];     // bytes waiting for the driver
  verdict_t            verdict_q [$];  // predicted verdicts, oldest first
  pkt_byte_t           cur_byte;
  bit                  sending = 1'b0; // driver holds a byte on the bus

  int unsigned         src_idle_pct = 15;
  int unsigned         snk_idle_pct = 60;
  int unsigned         cycle_count = 0;
  int unsigned         mismatches = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         packets_queued = 0;
  int unsigned         verdicts_checked = 0;
  int unsigned         found_count = 0;
  int unsigned         settings_used = 0;

  // ---------------------------------------------------------------------------
  // clock, reset, cycle counter
  // ---------------------------------------------------------------------------
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // pattern length in use, long settings clipped to the window
  function automatic int pattern_span();
    return (int'(cfg_len) > MaxPatternBytes) ? MaxPatternBytes : int'(cfg_len);
  endfunction

  function automatic logic [7:0] pattern_byte(input int i);
    if (i < 8) begin
      return cfg_pat_lo[8*i +: 8];
    end else begin
      return cfg_pat_hi[8*(i-8) +: 8];
    end
  endfunction

  // advance the packet state by one accepted byte; a last byte yields a verdict
  task automatic filter_byte(input pkt_byte_t b);
    int       span;
    bit       hit_now;
    verdict_t v;
    span = pattern_span();
    // payload bytes only, and nothing past the position limit
    if (pkt_pos != PosMax && int'(pkt_pos) >= int'(b.hdr) + UdpHeaderBytes) begin
      for (int i = MaxPatternBytes - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b.data;
      if (payload_cnt != PosMax) payload_cnt++;
      // pattern byte 0 sits deepest in the window, last byte newest
      hit_now = (span != 0) && (int'(payload_cnt) >= span);
      for (int i = 0; i < span; i++) begin
        if (win[span-1-i] != pattern_byte(i)) hit_now = 1'b0;
      end
      if (hit_now) hit = 1'b1;
    end
    if (pkt_pos != PosMax) pkt_pos++;
    if (b.is_last) begin
      if (!cfg_present) begin
        v = '{block: 1'b1, found: 1'b0};
      end else if (span == 0) begin
        v = '{block: 1'b0, found: 1'b0};
      end else begin
        v = '{block: hit && !cfg_replace, found: hit};
      end
      verdict_q.push_back(v);
      pkt_pos     = '0;
      payload_cnt = '0;
      hit         = 1'b0;
      win         = '{default: 8'h00};
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued bytes, predicts on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      sending = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_byte(cur_byte);
        bytes_sent++;
        sending = 1'b0;
      end
      // a held byte stays put; otherwise load the next one or idle
      if (!sending) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_byte = byte_q.pop_front();
          sending = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_byte.hdr, cur_byte.data};
          s_axis_tlast  <= cur_byte.is_last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back pressure, compares each verdict transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict transaction with none predicted: tdata %02h", m_axis_tdata);
          mismatches++;
        end else begin
          exp_v = verdict_q.pop_front();
          verdicts_checked++;
          if (m_axis_tdata[1]) found_count++;
          if (m_axis_tdata[0] !== exp_v.block) begin
            $error("verdict mismatch: expected %0b, got %0b", exp_v.block, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[1] !== exp_v.found) begin
            $error("pattern_found mismatch: expected %0b, got %0b",
                   exp_v.found, m_axis_tdata[1]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] d, input logic [7:0] h,
                                     input logic l);
    byte_q.push_back('{data: d, hdr: h, is_last: l});
  endfunction

  // wait until the block is quiet: nothing queued, on the bus or predicted,
  // then let any trailing non-last bytes work through the pipeline
  task automatic wait_idle();
    while (byte_q.size() != 0 || sending || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgFilterPresent: cfg_present = data[0];
      CfgPatternLength: cfg_len     = data[LenW-1:0];
      CfgPatternLow:    cfg_pat_lo  = data;
      CfgPatternHigh:   cfg_pat_hi  = data;
      CfgReplace:       cfg_replace = data[0];
      default: ;  // unmapped index is ignored
    endcase
  endtask

  task automatic set_filter(input logic present, input int len, input logic [63:0] lo,
                            input logic [63:0] hi, input logic replace);
    cfg_write(CfgFilterPresent, CfgDataW'(present));
    cfg_write(CfgPatternLength, CfgDataW'(len));
    cfg_write(CfgPatternLow, lo);
    cfg_write(CfgPatternHigh, hi);
    cfg_write(CfgReplace, CfgDataW'(replace));
    settings_used++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // build one packet; packet bytes lean toward pattern bytes to provoke near misses
  task automatic queue_packet(input int hdr, input int payload_len, input shape_e shape);
    logic [7:0] pkt [$];
    int         start;
    int         total;
    int         span;
    int         off;
    start = hdr + UdpHeaderBytes;
    total = start + payload_len;
    span  = pattern_span();
    for (int i = 0; i < total; i++) begin
      if (span != 0 && $urandom_range(1) == 1) begin
        pkt.push_back(pattern_byte($urandom_range(span - 1)));
      end else begin
        pkt.push_back(8'($urandom_range(255)));
      end
    end
    if (span != 0) begin
      case (shape)
        ShapeHit: begin
          // whole pattern somewhere in the payload
          if (payload_len >= span) begin
            off = start + $urandom_range(payload_len - span);
            for (int i = 0; i < span; i++) pkt[off+i] = pattern_byte(i);
          end
        end
        ShapeCut: begin
          // packet ends one byte before the pattern completes
          if (span > 1 && payload_len >= span - 1) begin
            for (int i = 0; i < span - 1; i++) pkt[total-span+1+i] = pattern_byte(i);
          end
        end
        ShapeInHeader: begin
          // pattern starts on the last udp header byte, so it never fits the payload
          if (payload_len >= span - 1) begin
            for (int i = 0; i < span; i++) pkt[start-1+i] = pattern_byte(i);
          end
        end
        default: ;
      endcase
    end
    // noise packets change the header length from byte to byte
    for (int i = 0; i < total; i++) begin
      queue_byte(pkt[i], (shape == ShapeNoise) ? 8'($urandom_range(255)) : 8'(hdr),
                 i == total - 1);
    end
    packets_queued++;
  endtask

  // random filter settings, the extremes among them
  task automatic apply_setting(input int k);
    case (k)
      0: set_filter(1'b1, 3, rand64(), rand64(), 1'b0);
      1: set_filter(1'b1, MaxPatternBytes, rand64(), rand64(), 1'b0);  // full window
      2: set_filter(1'b1, 1, rand64(), rand64(), 1'b1);                // single byte, replace
      3: set_filter(1'b0, 4, rand64(), rand64(), 1'b0);                // no filter context
      4: set_filter(1'b1, 0, rand64(), rand64(), 1'b0);                // empty pattern
      5: set_filter(1'b1, 31, rand64(), rand64(), 1'b1);               // longest length code
      6: set_filter(1'b1, 2, '1, '0, 1'b0);                            // all-ones bytes
      7: set_filter(1'b1, 8, '0, rand64(), 1'b0);                      // all-zero bytes
      8: begin
        cfg_write(CfgUnmapped, rand64());
        set_filter(1'b1, 5, rand64(), rand64(), 1'b0);
      end
      9: set_filter(1'b1, 17, rand64(), rand64(), 1'b0);               // just over the window
      default: set_filter($urandom_range(3) != 0, $urandom_range(20), rand64(), rand64(),
                          $urandom_range(1));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int     span;
    int     hdr;
    int     pick;
    shape_e shape;

    wait (rst_ni);
    @(posedge clk_i);

    // directed: reset config blocks everything; one-byte packet at field extremes
    queue_byte(8'hFF, 8'hFF, 1'b1);
    wait_idle();
    set_filter(1'b1, 3, rand64(), rand64(), 1'b0);
    // payload is exactly the pattern, completed on the last byte
    queue_packet(0, 3, ShapeHit);
    // packet ends inside the udp header
    queue_byte(8'h00, 8'h00, 1'b0);
    queue_byte(pattern_byte(0), 8'h00, 1'b0);
    queue_byte(pattern_byte(1), 8'h00, 1'b1);
    // replacement switched on mid-packet, before the matching byte arrives
    for (int i = 0; i < UdpHeaderBytes; i++) queue_byte(8'($urandom_range(255)), 8'h00, 1'b0);
    queue_byte(pattern_byte(0), 8'h00, 1'b0);
    queue_byte(pattern_byte(1), 8'h00, 1'b0);
    wait_idle();
    cfg_write(CfgReplace, CfgDataW'(1'b1));
    queue_byte(pattern_byte(2), 8'h00, 1'b1);

    // random: three idling regimes, four settings each, the sender paused between them
    for (int k = 0; k < 12; k++) begin
      case (k / 4)
        0: begin src_idle_pct = 15; snk_idle_pct = 60; end
        1: begin src_idle_pct = 60; snk_idle_pct = 15; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      wait_idle();
      apply_setting(k);
      for (int p = 0; p < 2; p++) begin
        span = pattern_span();
        if ($urandom_range(11) == 0) begin
          hdr = $urandom_range(40);
        end else begin
          hdr = $urandom_range(4);
        end
        pick = $urandom_range(99);
        if (pick < 40) shape = ShapeHit;
        else if (pick < 60) shape = ShapePlain;
        else if (pick < 75) shape = ShapeCut;
        else if (pick < 85) shape = ShapeInHeader;
        else shape = ShapeNoise;
        queue_packet(hdr, $urandom_range(span + 4), shape);
      end
    end

    // fresh setting, then a short packet shows the packet state starts clear
    wait_idle();
    set_filter(1'b1, 4, rand64(), rand64(), 1'b0);
    queue_packet(0, 6, ShapeHit);

    wait_idle();
    $display("covered %0d packets, %0d bytes and %0d filter settings under three idling regimes",
             packets_queued, bytes_sent, settings_used);
    $display("checked %0d verdicts, %0d with the pattern found", verdicts_checked, found_count);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
